### rtl/actuator_position_sequencer_macros.svh
// Assertion macros for the actuator position sequencer checker.
// Needs signals clk and arst_n in the scope of use.
`ifndef ACTUATOR_POSITION_SEQUENCER_MACROS_SVH
`define ACTUATOR_POSITION_SEQUENCER_MACROS_SVH

// Same-cycle implication, off during reset.
`define APS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aps checker: property failed");

// Next-cycle implication, off during reset.
`define APS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aps checker: property failed");

`endif

### rtl/aps_pkg.sv
// Shared types and constants for the actuator position sequencer.
// No dependencies.
package aps_pkg;

	localparam int CFG_W         = 12;
	localparam int CFG_IDX_W     = 3;
	localparam int SETTLE_W      = 8;
	localparam int POS_WIDTH_DEF = 12;

	typedef enum logic [2:0] {
		ST_INIT   = 3'd0,
		ST_IDLE   = 3'd1,
		ST_REQ    = 3'd2,
		ST_MOVING = 3'd3,
		ST_SET    = 3'd4,
		ST_DESYNC = 3'd5,
		ST_ERROR  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BWD  = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_STOP = 2'd1,
		CMD_FWD  = 2'd2,
		CMD_BWD  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_TARGET  = 2'd1,
		REQ_REAPPLY = 2'd2,
		REQ_STOP    = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FWD_LIMIT = 3'd0,
		CFG_BWD_LIMIT = 3'd1,
		CFG_TOLERANCE = 3'd2,
		CFG_DESYNC    = 3'd3,
		CFG_SETTLE    = 3'd4
	} cfg_idx_t;

endpackage

### rtl/aps_in_if.sv
// Input item channel of the actuator position sequencer.
// Depends on nothing but its width parameter.
interface aps_in_if #(
	parameter int POS_WIDTH = 12
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic [POS_WIDTH-1:0] feedback;
	logic [1:0]           actuator_dir;
	logic [POS_WIDTH-1:0] target;

	modport source (output valid, req_type, feedback, actuator_dir, target, input ready);
	modport sink (input valid, req_type, feedback, actuator_dir, target, output ready);
endinterface

### rtl/aps_out_if.sv
// Result channel of the actuator position sequencer.
// Depends on nothing but its width parameter.
interface aps_out_if #(
	parameter int POS_WIDTH = 12
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           motor_cmd;
	logic [2:0]           status;
	logic [POS_WIDTH-1:0] position;

	modport source (output valid, motor_cmd, status, position, input ready);
	modport sink (input valid, motor_cmd, status, position, output ready);
endinterface

### rtl/actuator_position_sequencer.sv
// Actuator position sequencer: one result per input transfer, one transfer per cycle unless stalled.
// Path: a taken transfer is registered in the input stage, then worked into the result
// register, from which the result shows valid.
// Throughput: one item every cycle; a stalled result stalls input only when both the
// input stage and the result register are full.
// Reset (arst_n low, async): status init, target/position/settle zero, registers at defaults.
module actuator_position_sequencer
	import aps_pkg::*;
#(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	aps_in_if.sink               item,
	aps_out_if.source            result
);

	// Common compare width for positions against 12-bit limits and tolerances.
	localparam int CW = (POS_WIDTH > CFG_W) ? POS_WIDTH : CFG_W;
	// Backward limit resets to the largest position that fits both widths.
	localparam logic [CFG_W-1:0] BWD_LIMIT_RST = (POS_WIDTH >= CFG_W) ?
		CFG_W'((2 ** CFG_W) - 1) : CFG_W'((2 ** POS_WIDTH) - 1);
	localparam logic [SETTLE_W-1:0] SETTLE_MAX = SETTLE_W'((2 ** SETTLE_W) - 1);

	// Configuration registers
	logic [CFG_W-1:0]    fwd_limit_q;
	logic [CFG_W-1:0]    bwd_limit_q;
	logic [CFG_W-1:0]    tolerance_q;
	logic [CFG_W-1:0]    desync_q;
	logic [SETTLE_W-1:0] settle_ticks_q;

	// Sequencer state
	status_t              status_q, status_d;
	logic [POS_WIDTH-1:0] target_q, target_d;
	logic [POS_WIDTH-1:0] position_q, position_d;
	dir_t                 direction_q, direction_d;
	logic [SETTLE_W-1:0]  settle_q, settle_d;

	// Input stage
	logic                 valid_s1;
	req_t                 req_s1;
	logic [POS_WIDTH-1:0] feedback_s1;
	logic [1:0]           act_dir_s1;
	logic [POS_WIDTH-1:0] target_s1;

	// Result register
	logic                 out_valid_q;
	cmd_t                 cmd_q;
	status_t              out_status_q;
	logic [POS_WIDTH-1:0] out_pos_q;

	logic                 advance;
	cmd_t                 cmd_d;
	logic [POS_WIDTH-1:0] pos_diff;
	logic [SETTLE_W-1:0]  settle_inc;
	logic                 in_limits;
	logic                 reached;
	logic                 past;

	// Work the staged item whenever the result register is free or being drained.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_limit_q    <= '0;
			bwd_limit_q    <= BWD_LIMIT_RST;
			tolerance_q    <= CFG_W'(8);
			desync_q       <= CFG_W'(32);
			settle_ticks_q <= SETTLE_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FWD_LIMIT: fwd_limit_q    <= cfg_data;
				CFG_BWD_LIMIT: bwd_limit_q    <= cfg_data;
				CFG_TOLERANCE: tolerance_q    <= cfg_data;
				CFG_DESYNC:    desync_q       <= cfg_data;
				CFG_SETTLE:    settle_ticks_q <= cfg_data[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage: hold the item until it is worked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			req_s1      <= req_t'(item.req_type);
			feedback_s1 <= item.feedback;
			act_dir_s1  <= item.actuator_dir;
			target_s1   <= item.target;
		end
	end

	// State register: advance once per worked item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= ST_INIT;
			target_q    <= '0;
			position_q  <= '0;
			direction_q <= DIR_NONE;
			settle_q    <= '0;
		end else if (advance) begin
			status_q    <= status_d;
			target_q    <= target_d;
			position_q  <= position_d;
			direction_q <= direction_d;
			settle_q    <= settle_d;
		end
	end

	// Distance from the target to the fresh sample; only ticks use it.
	always_comb begin
		pos_diff = (target_q >= feedback_s1) ? (target_q - feedback_s1) :
			(feedback_s1 - target_q);
		settle_inc = (settle_q == SETTLE_MAX) ? settle_q : (settle_q + SETTLE_W'(1));
		in_limits = (CW'(target_q) >= CW'(fwd_limit_q)) && (CW'(target_q) <= CW'(bwd_limit_q));
		past = ((direction_q == DIR_BWD) && (target_q < feedback_s1)) ||
		       ((direction_q == DIR_FWD) && (target_q > feedback_s1));
		reached = past || (CW'(pos_diff) <= CW'(tolerance_q));
	end

	// Next state and motor command for the staged item.
	always_comb begin
		status_d    = status_q;
		target_d    = target_q;
		position_d  = position_q;
		direction_d = direction_q;
		settle_d    = settle_q;
		cmd_d       = CMD_NONE;

		unique case (req_s1)
			REQ_TICK: begin
				position_d = feedback_s1;
				unique case (status_q)
					ST_INIT: begin
						status_d = ST_IDLE;
					end
					ST_REQ: begin
						if (!in_limits) begin
							status_d = ST_ERROR;
						end else if (CW'(pos_diff) <= CW'(desync_q >> 1)) begin
							// Inside the deadband: count as set at once.
							status_d = ST_SET;
						end else begin
							direction_d = (target_q >= feedback_s1) ? DIR_BWD : DIR_FWD;
							settle_d    = '0;
							status_d    = ST_MOVING;
						end
					end
					ST_MOVING: begin
						settle_d = reached ? settle_inc : '0;
						if (reached && (settle_inc >= settle_ticks_q)) begin
							cmd_d    = CMD_STOP;
							status_d = ST_SET;
						end else if (direction_q == DIR_BWD) begin
							cmd_d = (act_dir_s1 != DIR_BWD) ? CMD_BWD : CMD_NONE;
						end else if (direction_q == DIR_FWD) begin
							cmd_d = (act_dir_s1 != DIR_FWD) ? CMD_FWD : CMD_NONE;
						end else begin
							// Moving with no direction left: stop and flag.
							cmd_d    = CMD_STOP;
							status_d = ST_ERROR;
						end
					end
					ST_SET: begin
						if (CW'(pos_diff) >= CW'(desync_q)) begin
							status_d = ST_DESYNC;
						end
					end
					default: ;
				endcase
			end
			REQ_TARGET, REQ_REAPPLY: begin
				if (status_q != ST_ERROR) begin
					if (status_q == ST_MOVING) begin
						direction_d = DIR_NONE;
						cmd_d       = CMD_STOP;
					end
					if (req_s1 == REQ_TARGET) begin
						target_d = target_s1;
					end
					status_d = ST_REQ;
				end
			end
			REQ_STOP: begin
				cmd_d = CMD_STOP;
				if (status_q != ST_ERROR) begin
					status_d = ST_IDLE;
				end
			end
			default: ;
		endcase
	end

	// Result register: load on advance, drop on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q        <= cmd_d;
			out_status_q <= status_d;
			out_pos_q    <= (status_d == ST_ERROR) ? '0 : position_d;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.motor_cmd = cmd_q;
	assign result.status    = out_status_q;
	assign result.position  = out_pos_q;

endmodule

### rtl/aps_checker.sv
// Port-level checker for the actuator position sequencer, bound to the top level.
// Depends on aps_pkg and actuator_position_sequencer_macros.svh.
`include "actuator_position_sequencer_macros.svh"

module aps_checker
	import aps_pkg::*;
#(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [1:0]           motor_cmd,
	input logic [2:0]           status,
	input logic [POS_WIDTH-1:0] position
);

	logic err_seen_q;

	// Remember a transferred error result; error is sticky.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready && (status == ST_ERROR)) begin
			err_seen_q <= 1'b1;
		end
	end

	`APS_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(motor_cmd) && $stable(status) && $stable(position))
	`APS_ASSERT_IMP(a_err_pos_zero, out_valid && (status == ST_ERROR), position == '0)
	`APS_ASSERT_IMP(a_err_sticky, out_valid && err_seen_q, status == ST_ERROR)
	`APS_ASSERT_IMP(a_drive_moving, out_valid && ((motor_cmd == CMD_FWD) || (motor_cmd == CMD_BWD)), status == ST_MOVING)

endmodule

bind actuator_position_sequencer aps_checker #(
	.POS_WIDTH(POS_WIDTH)
) u_aps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.motor_cmd (result.motor_cmd),
	.status    (result.status),
	.position  (result.position)
);
